// ===== rtl/core/dpps_pkg.sv =====
// Shared types and constants of the dynamic priority process scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dpps_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 16;
  localparam int TIME_W = 16;

  // One process table entry as it travels around the ring of cells.
  typedef struct packed {
    logic                     valid;
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [TIME_W-1:0]        time_left;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/dpps_cell.sv =====
// One cell of the process table ring: holds an entry and passes it on.
`timescale 1ns / 1ps
`default_nettype none

module dpps_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire dpps_pkg::entry_t d_in,
  output      dpps_pkg::entry_t q
);
  import dpps_pkg::*;

  // Only the valid flag needs a reset; payload is don't-care while invalid.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q <= d_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dynamic_priority_process_scheduler.sv =====
// Top level of the dynamic priority process scheduler.
`timescale 1ns / 1ps
`default_nettype none

// The process table is a ring of TableDepth cells that rotates one place per
// cycle while a request is worked on, past a single comparator at the head
// cell. An add request (tuser 0) makes one full rotation and drops the new
// process into the first free slot as it passes. A schedule request (tuser 1)
// makes one rotation to find the best process (highest priority, then least
// time left, then lowest id, then lowest slot) and, if one is found, a second
// rotation to write the updated entry back. One request is worked on at a
// time. The output register lets a new request be accepted while the previous
// result waits to be taken. No clearing pass is needed after reset. Registers:
// quantum at 0x0, priority step at 0x4, both reset to 1.
module dynamic_priority_process_scheduler #(
  parameter int TableDepth = dpps_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // request stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // new_priority[7:0], required_time[23:8]
  input  wire logic        s_tuser,  // mode
  // result stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // process_id[15:0], priority_after[31:16], time_left_after[47:32],
  // ready_count from bit 48 up, zero padding above
  output      logic [((48 + $clog2(TableDepth + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  output      logic [2:0]  m_tuser   // status
);
  import dpps_pkg::*;

  localparam int IDX_W = $clog2(TableDepth);
  localparam int CNT_W = $clog2(TableDepth + 1);
  localparam int OUT_W = ((48 + CNT_W + 7) / 8) * 8;

  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_STEP    = 1'b1;
  localparam logic MODE_ADD    = 1'b0;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_RAN      = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    UPDATE,
    FINISH
  } state_t;

  function automatic logic better(input entry_t a, input entry_t b);
    if (a.prio != b.prio) begin
      better = a.prio > b.prio;
    end else if (a.time_left != b.time_left) begin
      better = a.time_left < b.time_left;
    end else begin
      better = a.id < b.id;
    end
  endfunction

  state_t             state;
  logic               mode;
  logic signed [15:0] new_prio;
  logic [15:0]        req_time;
  logic [IDX_W-1:0]   cnt;
  logic               slot_found;
  logic               best_found;
  entry_t             best;
  logic [IDX_W-1:0]   best_idx;
  logic [CNT_W-1:0]   process_count;
  logic [15:0]        next_id;
  logic [7:0]         quantum;
  logic [7:0]         priority_step;

  status_t            res_status;
  logic [15:0]        res_id;
  logic signed [15:0] res_prio;
  logic [15:0]        res_time;

  logic               out_valid;
  logic               out_load;
  status_t            out_status;
  logic [15:0]        out_id;
  logic signed [15:0] out_prio;
  logic [15:0]        out_time;
  logic [CNT_W-1:0]   out_count;

  entry_t             ring [TableDepth];
  entry_t             head;
  entry_t             ring_in;
  entry_t             new_entry;
  entry_t             upd_entry;
  logic               shift;
  logic               last;
  logic               take_slot;
  logic               take_best;
  logic               write_upd;
  logic [15:0]        t_after;
  logic signed [16:0] p_diff;
  logic signed [15:0] p_after;
  logic [15:0]        id_inc;
  logic               cfg_write;

  // ring of cells: cell i takes from cell i+1, the tail takes from the head or a new or updated entry
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == TableDepth - 1) begin : g_tail
      dpps_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d_in(ring_in), .q(ring[i]));
    end else begin : g_body
      dpps_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d_in(ring[i+1]), .q(ring[i]));
    end
  end

  assign head  = ring[0];
  assign shift = (state == SCAN) || (state == UPDATE);
  assign last  = cnt == IDX_W'(TableDepth - 1);

  assign take_slot = (state == SCAN) && (mode == MODE_ADD) && !slot_found && !head.valid;
  assign take_best = (state == SCAN) && (mode != MODE_ADD) && head.valid &&
                     (!best_found || better(head, best));
  assign write_upd = (state == UPDATE) && (cnt == best_idx);

  // clamp time at zero, saturate priority at the most negative value
  assign t_after = (best.time_left > {8'd0, quantum}) ? best.time_left - {8'd0, quantum}
                                                      : 16'd0;
  assign p_diff  = {best.prio[15], best.prio} - $signed({9'd0, priority_step});
  assign p_after = (p_diff[16] && !p_diff[15]) ? 16'sh8000 : p_diff[15:0];

  assign new_entry = '{valid: 1'b1, id: next_id, prio: new_prio, time_left: req_time};
  assign upd_entry = '{valid: t_after != 16'd0, id: best.id, prio: p_after,
                       time_left: t_after};

  always_comb begin
    if (take_slot) begin
      ring_in = new_entry;
    end else if (write_upd) begin
      ring_in = upd_entry;
    end else begin
      ring_in = head;
    end
  end

  assign id_inc    = next_id + 16'd1;
  assign cfg_write = psel && penable && pwrite;
  assign out_load  = (state == FINISH) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      out_valid     <= 1'b0;
      process_count <= '0;
      next_id       <= 16'd1;
      quantum       <= 8'd1;
      priority_step <= 8'd1;
      slot_found    <= 1'b0;
      best_found    <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          REG_QUANTUM: quantum       <= pwdata[7:0];
          REG_STEP:    priority_step <= pwdata[7:0];
          default:     ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            mode       <= s_tuser;
            new_prio   <= {{8{s_tdata[7]}}, s_tdata[7:0]};
            req_time   <= s_tdata[23:8];
            cnt        <= '0;
            slot_found <= 1'b0;
            best_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          cnt <= last ? '0 : cnt + IDX_W'(1);
          if (take_slot) begin
            slot_found <= 1'b1;
          end
          if (take_best) begin
            best       <= head;
            best_idx   <= cnt;
            best_found <= 1'b1;
          end
          if (last) begin
            if (mode == MODE_ADD) begin
              state <= FINISH;
              if (slot_found || take_slot) begin
                res_status    <= ST_ADDED;
                res_id        <= next_id;
                res_prio      <= new_prio;
                res_time      <= req_time;
                next_id       <= (id_inc == 16'd0) ? 16'd1 : id_inc;
                process_count <= process_count + CNT_W'(1);
              end else begin
                res_status <= ST_FULL;
                res_id     <= 16'd0;
                res_prio   <= 16'sd0;
                res_time   <= 16'd0;
              end
            end else if (best_found || take_best) begin
              state <= UPDATE;
            end else begin
              res_status <= ST_EMPTY;
              res_id     <= 16'd0;
              res_prio   <= 16'sd0;
              res_time   <= 16'd0;
              state      <= FINISH;
            end
          end
        end
        UPDATE: begin
          cnt <= last ? '0 : cnt + IDX_W'(1);
          if (last) begin
            res_id     <= best.id;
            res_prio   <= p_after;
            res_time   <= t_after;
            res_status <= (t_after == 16'd0) ? ST_FINISHED : ST_RAN;
            if (t_after == 16'd0) begin
              process_count <= process_count - CNT_W'(1);
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          // hold the result until the output register is free
          if (out_load) begin
            out_status <= res_status;
            out_id     <= res_id;
            out_prio   <= res_prio;
            out_time   <= res_time;
            out_count  <= process_count;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE) && !rst;
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_W'({out_count, out_time, out_prio, out_id});

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum} : {24'd0, priority_step};

`ifndef ASSERT_OFF
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && res_status == ST_FULL) |-> process_count == CNT_W'(TableDepth))
    else $error("table full reported with free entries");

  a_empty_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && res_status == ST_EMPTY) |-> process_count == '0)
    else $error("no process reported with a nonzero count");

  a_update_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == UPDATE) |-> best_found)
    else $error("write-back pass without a chosen entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    process_count <= CNT_W'(TableDepth))
    else $error("process count exceeds table depth");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking stream testbench of the dynamic priority process scheduler.
`timescale 1ns / 1ps

module testbench;
  import dpps_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int RES_W          = ((48 + CNT_W + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam int PRIO_FLOOR     = -32768;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_SCHEDULE = 1'b1;

  localparam int REG_QUANTUM       = 0;
  localparam int REG_PRIORITY_STEP = 1;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_RAN      = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } sched_status_t;

  typedef struct {
    sched_status_t            status;
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [TIME_W-1:0]        time_left;
    logic [CNT_W-1:0]         ready;
  } sched_result_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             psel     = 1'b0;
  logic             penable  = 1'b0;
  logic             pwrite   = 1'b0;
  logic [2:0]       paddr    = '0;
  logic [31:0]      pwdata   = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata  = '0;  // new_priority[7:0], required_time[23:8]
  logic             s_tuser  = 1'b0;  // mode
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // process_id[15:0], priority_after[31:16], time_left_after[47:32],
  // ready_count from bit 48 up, zero padding above
  logic [RES_W-1:0] m_tdata;
  logic [2:0]       m_tuser;  // status

  // Mirror of the process table and the registers
  bit              tbl_valid [DEPTH];
  logic [ID_W-1:0] tbl_id    [DEPTH];
  int              tbl_prio  [DEPTH];
  int              tbl_time  [DEPTH];
  logic [ID_W-1:0] id_counter  = 1;
  int              ready_count = 0;
  int              cur_quantum = 1;
  int              cur_step    = 1;

  sched_result_t pending_results [$];

  int mismatch_count = 0;
  int status_seen [5];
  int config_writes  = 0;
  int lowest_prio    = 0;
  int idle_cycles    = 0;

  int burst_left = 0;
  int gap_max    = 3;
  int stall_max  = 4;
  bit ready_hold = 1'b0;
  int ready_run  = 0;

  dynamic_priority_process_scheduler #(
    .TableDepth(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Apply one request to the table mirror and return the result it causes.
  function automatic sched_result_t schedule_model(input logic mode, input logic [7:0] pri,
                                                   input logic [15:0] req);
    sched_result_t r;
    int slot;
    int best;
    int t;
    int p;
    r.status    = ST_ADDED;
    r.id        = '0;
    r.prio      = '0;
    r.time_left = '0;
    slot        = -1;
    best        = -1;
    if (mode == MODE_ADD) begin
      for (int i = 0; i < DEPTH; i++)
        if (!tbl_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_id[slot]    = id_counter;
        tbl_prio[slot]  = int'($signed(pri));
        tbl_time[slot]  = int'(req);
        r.id            = id_counter;
        r.prio          = PRIO_W'(tbl_prio[slot]);
        r.time_left     = req;
        id_counter++;
        if (id_counter == 0) id_counter = 1;
        ready_count++;
      end
    end else begin
      // highest priority, then least time left, then lowest id, then lowest slot
      for (int i = 0; i < DEPTH; i++)
        if (tbl_valid[i] && (best < 0 || tbl_prio[i] > tbl_prio[best] ||
            (tbl_prio[i] == tbl_prio[best] && (tbl_time[i] < tbl_time[best] ||
             (tbl_time[i] == tbl_time[best] && tbl_id[i] < tbl_id[best])))))
          best = i;
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        t = (tbl_time[best] > cur_quantum) ? tbl_time[best] - cur_quantum : 0;
        p = tbl_prio[best] - cur_step;
        if (p < PRIO_FLOOR) p = PRIO_FLOOR;
        tbl_time[best] = t;
        tbl_prio[best] = p;
        r.id           = tbl_id[best];
        r.prio         = PRIO_W'(p);
        r.time_left    = TIME_W'(t);
        if (t == 0) begin
          tbl_valid[best] = 1'b0;
          ready_count--;
          r.status = ST_FINISHED;
        end else begin
          r.status = ST_RAN;
        end
      end
    end
    r.ready = CNT_W'(ready_count);
    return r;
  endfunction

  function automatic logic [7:0] rand_priority();
    case ($urandom_range(3))
      0: return 8'($urandom_range(2)) - 8'd1;  // cluster around zero to force ties
      1: return $urandom_range(1) ? 8'h7F : 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short jobs so that processes finish and slots get reused.
  function automatic logic [15:0] rand_required_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return 16'($urandom_range(2 * cur_quantum + 1));
    if (pick < 78) return 16'($urandom_range(8 * cur_quantum + 4));
    if (pick < 96) return 16'($urandom_range(4));
    return 16'($urandom);
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic mode, input logic [7:0] pri, input logic [15:0] req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {req, pri};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(schedule_model(mode, pri, req));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input int idx, input logic [7:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * idx);
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != 32'(value))
      report_mismatch(idx == REG_QUANTUM ? "quantum readback" : "priority_step readback",
                      readback, value);
    if (idx == REG_QUANTUM) cur_quantum = int'(value);
    else cur_step = int'(value);
    config_writes++;
  endtask

  task automatic configure(input int quantum_val, input int step_val);
    wait_idle();
    write_register(REG_QUANTUM, 8'(quantum_val));
    write_register(REG_PRIORITY_STEP, 8'(step_val));
  endtask

  // Two long jobs run alternately under a steep step until both sit at the floor.
  task automatic test_priority_floor();
    configure(1, 255);
    send_request(MODE_ADD, 8'h80, 16'd300);
    send_request(MODE_ADD, rand_priority(), 16'd300);
    repeat (280) send_request(MODE_SCHEDULE, rand_priority(), rand_required_time());
    configure(255, 255);
    // finish both, then schedule on the empty table
    repeat (3) send_request(MODE_SCHEDULE, rand_priority(), rand_required_time());
  endtask

  task automatic test_directed();
    configure(1, 1);
    send_request(MODE_SCHEDULE, 8'h00, 16'h0000);
    send_request(MODE_ADD, 8'h7F, 16'hFFFF);
    send_request(MODE_ADD, 8'h80, 16'h0000);
    send_request(MODE_ADD, 8'h00, 16'h0001);
    send_request(MODE_ADD, 8'h00, 16'h0001);
    send_request(MODE_ADD, 8'h00, 16'h0002);
    send_request(MODE_ADD, 8'h7F, 16'hFFFF);
    send_request(MODE_ADD, 8'h55, 16'hAAAA);
    send_request(MODE_ADD, 8'hAA, 16'h5555);
    repeat (9) send_request(MODE_SCHEDULE, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_zero_quantum_and_step();
    configure(0, 0);
    send_request(MODE_ADD, 8'h7F, 16'h0000);
    send_request(MODE_ADD, 8'h7F, 16'h0003);
    repeat (3) send_request(MODE_SCHEDULE, 8'h00, 16'h0000);
  endtask

  task automatic test_table_full();
    gap_max   = 0;
    stall_max = 0;
    while (ready_count < DEPTH)
      send_request(MODE_ADD, rand_priority(), rand_required_time());
    repeat (2) send_request(MODE_ADD, rand_priority(), rand_required_time());
    send_request(MODE_SCHEDULE, 8'h00, 16'h0000);
    send_request(MODE_ADD, rand_priority(), rand_required_time());
  endtask

  task automatic run_random_phase(input int quantum_val, input int step_val, input int n_items,
                                  input int add_pct, input int gaps, input int stalls);
    configure(quantum_val, step_val);
    gap_max   = gaps;
    stall_max = stalls;
    for (int n = 0; n < n_items; n++)
      send_request(($urandom_range(99) < add_pct) ? MODE_ADD : MODE_SCHEDULE,
                   rand_priority(), rand_required_time());
  endtask

  task automatic test_random_mix();
    run_random_phase(1, 1, 200, 55, 6, 8);
    run_random_phase(255, 255, 200, 50, 0, 0);
    run_random_phase(0, 0, 200, 60, 20, 20);
    run_random_phase($urandom_range(2, 254), $urandom_range(255), 200, 50, 3, 5);
    run_random_phase(255, 0, 200, 35, 10, 0);
    run_random_phase(1, 255, 200, 45, 0, 12);
    run_random_phase(7, 3, 200, 50, 0, 0);
  endtask

  // Receiver: alternate ready and stall runs of random length.
  always @(negedge clk) begin
    if (stall_max == 0) begin
      m_tready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_hold = !ready_hold;
        ready_run  = ready_hold ? $urandom_range(1, 10) : $urandom_range(1, stall_max);
      end
      ready_run--;
      m_tready <= ready_hold;
    end
  end

  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", m_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser != want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[15:0] != want.id)
          report_mismatch("process_id", m_tdata[15:0], want.id);
        if ($signed(m_tdata[31:16]) != want.prio)
          report_mismatch("priority_after", $signed(m_tdata[31:16]), want.prio);
        if (m_tdata[47:32] != want.time_left)
          report_mismatch("time_left_after", m_tdata[47:32], want.time_left);
        if (m_tdata[48 +: CNT_W] != want.ready)
          report_mismatch("ready_count", m_tdata[48 +: CNT_W], want.ready);
        status_seen[want.status]++;
        if (want.prio < lowest_prio) lowest_prio = int'(want.prio);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_priority_floor();
    test_directed();
    test_zero_quantum_and_step();
    test_table_full();
    test_random_mix();
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d added, %0d ran, %0d finished, %0d empty-table, %0d full-table results",
             status_seen[ST_ADDED], status_seen[ST_RAN], status_seen[ST_FINISHED],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("%0d register writes, lowest priority reported %0d, %0d mismatches",
             config_writes, lowest_prio, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== dynamic_priority_process_scheduler.f =====
rtl/core/dpps_pkg.sv
rtl/core/dpps_cell.sv
rtl/core/dynamic_priority_process_scheduler.sv
verif/testbench.sv
